@@ sv/dpdd_pkg.sv @@
package dpdd_pkg;

  localparam int unsigned TableDepth = 32;
  localparam int unsigned TableIdxW  = $clog2(TableDepth);
  localparam int unsigned TaskIdW    = 16;
  localparam int unsigned DeadlineW  = 31;
  localparam int unsigned EntryW     = TaskIdW + 1 + DeadlineW;

  typedef enum logic [2:0] {
    MODE_TIMER    = 3'd0,
    MODE_ARRIVAL  = 3'd1,
    MODE_FINISH   = 3'd2,
    MODE_IO_REQ   = 3'd3,
    MODE_IO_END   = 3'd4,
    MODE_DISPATCH = 3'd5
  } mode_e;

  // Work done on one task table during a scan.
  typedef enum logic [1:0] {
    TOP_NONE,
    TOP_PUSH,
    TOP_REMOVE,
    TOP_POP
  } tbl_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]           mode;
    logic [TaskIdW-1:0]   task_id;
    logic                 high_priority;
    logic [DeadlineW-1:0] deadline;
  } evt_t;

  typedef struct packed {
    logic               cpu_valid;
    logic [TaskIdW-1:0] cpu_task;
    logic               io_valid;
    logic [TaskIdW-1:0] io_task;
    logic               overflowed;
  } res_t;

  typedef struct packed {
    logic [TaskIdW-1:0]   task_id;
    logic                 high_priority;
    logic [DeadlineW-1:0] deadline;
  } entry_t;

  // Running results of one table scan.
  typedef struct packed {
    logic                 free_found;
    logic [TableIdxW-1:0] free_idx;
    logic                 best_found;
    logic [TableIdxW-1:0] best_idx;
    logic                 best_high;
    logic [DeadlineW-1:0] best_dl;
    logic [TaskIdW-1:0]   best_id;
  } track_t;

endpackage

@@ sv/dpdd_ram.sv @@
module dpdd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dual_priority_deadline_dispatcher_unit.sv @@
// Two-level priority, earliest-deadline-first dispatcher.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) carries one event beat:
// timer, arrival, finish, I/O request, I/O end or dispatch. Output channel
// (out_valid_o / out_ready_i / out_data_o) carries one result beat for each
// dispatch event only: the popped CPU and I/O task ids and the sticky
// overflow flag.
//
// Each table keeps its entries in a small RAM with a valid bit per slot.
// Every real event is one linear scan over both tables, one slot per cycle
// through the RAM read port: the scan steps, a tail step for the last read
// and a commit step, after which the next event is accepted. A dispatch
// result is registered from its commit step. Timer events and unused
// modes are taken and dropped without a scan. A waiting result does not
// block the next scan; a second dispatch that finishes while it still waits
// holds in its commit step until the output register frees up.
// Reset clears all valid bits, the overflow flag and the output valid; the
// block is ready for an event in the first cycle after reset.
module dual_priority_deadline_dispatcher_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  dpdd_pkg::evt_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dpdd_pkg::res_t   out_data_o
);

  localparam int unsigned Depth = dpdd_pkg::TableDepth;
  localparam int unsigned IdxW  = dpdd_pkg::TableIdxW;

  // Control state
  dpdd_pkg::state_e          state_q, state_d;
  logic [IdxW-1:0]           idx_q, idx_d;     // RAM read address of the scan
  logic [IdxW-1:0]           k_q;              // slot whose data is on the RAM output
  logic [1:0][Depth-1:0]     valid_q, valid_d; // index 0 CPU table, 1 I/O table
  logic                      ovf_q, ovf_d;
  dpdd_pkg::tbl_op_e [1:0]   op_q, op_d;
  dpdd_pkg::track_t  [1:0]   trk_q, trk_d;
  logic                      out_valid_q, out_valid_d;

  // Payload
  dpdd_pkg::evt_t            evt_q, evt_d;
  dpdd_pkg::res_t            out_q, out_d;

  // RAM ports
  logic [1:0]                ram_we;
  dpdd_pkg::entry_t          wr_entry;
  logic [1:0][IdxW-1:0]      wr_addr;
  dpdd_pkg::entry_t [1:0]    rd_entry;

  for (genvar t = 0; t < 2; t++) begin : g_tbl
    dpdd_ram #(
      .Width (dpdd_pkg::EntryW),
      .Depth (Depth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[t]),
      .waddr_i (wr_addr[t]),
      .wdata_i (wr_entry),
      .raddr_i (idx_q),
      .rdata_o (rd_entry[t])
    );
  end

  assign wr_entry.task_id       = evt_q.task_id;
  assign wr_entry.high_priority = evt_q.high_priority;
  assign wr_entry.deadline      = evt_q.deadline;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpdd_pkg::ST_IDLE;
      idx_q       <= '0;
      k_q         <= '0;
      valid_q     <= '0;
      ovf_q       <= 1'b0;
      op_q        <= '{dpdd_pkg::TOP_NONE, dpdd_pkg::TOP_NONE};
      trk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      k_q         <= idx_q;
      valid_q     <= valid_d;
      ovf_q       <= ovf_d;
      op_q        <= op_d;
      trk_q       <= trk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
    out_q <= out_d;
  end

  always_comb begin
    dpdd_pkg::entry_t ent;
    logic             vbit;
    logic             proc;
    logic             better;
    logic             advance;
    logic             is_pop;

    state_d     = state_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    ovf_d       = ovf_q;
    op_d        = op_q;
    trk_d       = trk_q;
    evt_d       = evt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    ram_we      = '0;
    wr_addr     = '0;
    ent         = '0;
    vbit        = 1'b0;
    better      = 1'b0;
    is_pop      = (op_q[0] == dpdd_pkg::TOP_POP);
    advance     = !is_pop || !out_valid_q || out_ready_i;

    // Data of slot k_q is on the RAM output in every scan cycle but the first.
    proc = ((state_q == dpdd_pkg::ST_SCAN) && (idx_q != '0)) ||
           (state_q == dpdd_pkg::ST_TAIL);

    if (proc) begin
      for (int t = 0; t < 2; t++) begin
        ent  = rd_entry[t];
        vbit = valid_q[t][k_q];
        case (op_q[t])
          dpdd_pkg::TOP_PUSH: begin
            // Remember the lowest free slot.
            if (!vbit && !trk_q[t].free_found) begin
              trk_d[t].free_found = 1'b1;
              trk_d[t].free_idx   = k_q;
            end
          end
          dpdd_pkg::TOP_REMOVE: begin
            if (vbit && (ent.task_id == evt_q.task_id)) begin
              valid_d[t][k_q] = 1'b0;
            end
          end
          dpdd_pkg::TOP_POP: begin
            // High priority wins, then strictly smaller deadline; ties keep
            // the lower slot.
            if (ent.high_priority != trk_q[t].best_high) begin
              better = ent.high_priority;
            end else begin
              better = (ent.deadline < trk_q[t].best_dl);
            end
            if (vbit && (!trk_q[t].best_found || better)) begin
              trk_d[t].best_found = 1'b1;
              trk_d[t].best_idx   = k_q;
              trk_d[t].best_high  = ent.high_priority;
              trk_d[t].best_dl    = ent.deadline;
              trk_d[t].best_id    = ent.task_id;
            end
          end
          default: begin
          end
        endcase
      end
    end

    case (state_q)
      dpdd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          evt_d   = in_data_i;
          trk_d   = '0;
          idx_d   = '0;
          state_d = dpdd_pkg::ST_SCAN;
          case (in_data_i.mode)
            dpdd_pkg::MODE_ARRIVAL:  op_d = '{dpdd_pkg::TOP_NONE,   dpdd_pkg::TOP_PUSH};
            dpdd_pkg::MODE_FINISH:   op_d = '{dpdd_pkg::TOP_REMOVE, dpdd_pkg::TOP_REMOVE};
            dpdd_pkg::MODE_IO_REQ:   op_d = '{dpdd_pkg::TOP_PUSH,   dpdd_pkg::TOP_REMOVE};
            dpdd_pkg::MODE_IO_END:   op_d = '{dpdd_pkg::TOP_REMOVE, dpdd_pkg::TOP_PUSH};
            dpdd_pkg::MODE_DISPATCH: op_d = '{dpdd_pkg::TOP_POP,    dpdd_pkg::TOP_POP};
            default: begin
              // Timer and unused modes: drop the beat.
              op_d    = '{dpdd_pkg::TOP_NONE, dpdd_pkg::TOP_NONE};
              state_d = dpdd_pkg::ST_IDLE;
            end
          endcase
        end
      end
      dpdd_pkg::ST_SCAN: begin
        if (idx_q == IdxW'(Depth - 1)) begin
          idx_d   = '0;
          state_d = dpdd_pkg::ST_TAIL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      dpdd_pkg::ST_TAIL: begin
        state_d = dpdd_pkg::ST_DONE;
      end
      dpdd_pkg::ST_DONE: begin
        // Commit pushes and pops; hold while a dispatch result cannot be loaded.
        if (advance) begin
          for (int t = 0; t < 2; t++) begin
            case (op_q[t])
              dpdd_pkg::TOP_PUSH: begin
                if (trk_q[t].free_found) begin
                  ram_we[t]                       = 1'b1;
                  wr_addr[t]                      = trk_q[t].free_idx;
                  valid_d[t][trk_q[t].free_idx]   = 1'b1;
                end else begin
                  ovf_d = 1'b1;
                end
              end
              dpdd_pkg::TOP_POP: begin
                if (trk_q[t].best_found) begin
                  valid_d[t][trk_q[t].best_idx] = 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
          if (is_pop) begin
            out_valid_d      = 1'b1;
            out_d.cpu_valid  = trk_q[0].best_found;
            out_d.cpu_task   = trk_q[0].best_found ? trk_q[0].best_id : '0;
            out_d.io_valid   = trk_q[1].best_found;
            out_d.io_task    = trk_q[1].best_found ? trk_q[1].best_id : '0;
            out_d.overflowed = ovf_q;
          end
          state_d = dpdd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dpdd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A dispatch that cannot load its result must stay in its final step.
  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpdd_pkg::ST_DONE) && (op_q[0] == dpdd_pkg::TOP_POP) &&
    out_valid_q && !out_ready_i |=> (state_q == dpdd_pkg::ST_DONE))
    else $error("dispatch left its final step while the result was stalled");

  // Overflow only rises when a push is committed.
  a_ovf_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovf_q) |-> ($past(state_q) == dpdd_pkg::ST_DONE))
    else $error("overflow flag set outside of a commit");

  // An empty pop reports a zero id.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.cpu_valid || (out_q.cpu_task == '0)) &&
                     (out_q.io_valid || (out_q.io_task == '0))))
    else $error("empty dispatch carries a nonzero task id");

  // The scan address is parked at zero outside the scan.
  a_idx_park: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dpdd_pkg::ST_SCAN) |-> (idx_q == '0))
    else $error("scan address not parked");

endmodule
